### sv/rtc_cal_pkg.sv
// Package for the RTC epoch/calendar converter: calendar constants, divider
// seeds and the year and month length functions.
// No dependencies.
`default_nettype none

package rtc_cal_pkg;

    localparam logic [11:0] BASE_YEAR      = 12'd2010;
    localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
    localparam logic [11:0] NOLEAP_CENTURY = 12'd2100;
    localparam logic [3:0]  LAST_MONTH     = 4'd12;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;
    localparam logic [31:0] WEEKDAY_BIAS  = 32'd4;

    localparam int DAY_STEPS  = 16;
    localparam int HOUR_STEPS = 5;
    localparam int MIN_STEPS  = 6;
    localparam int WK_STEPS   = 13;

    localparam logic [31:0] DAY_DVS  = 32'(SECS_PER_DAY) << (DAY_STEPS - 1);
    localparam logic [31:0] HOUR_DVS = 32'(SECS_PER_HOUR) << (HOUR_STEPS - 1);
    localparam logic [31:0] MIN_DVS  = 32'(SECS_PER_MIN) << (MIN_STEPS - 1);
    localparam logic [31:0] WK_DVS   = 32'd7 << (WK_STEPS - 1);

    localparam logic [3:0] DAY_LAST_STEP  = 4'(DAY_STEPS - 1);
    localparam logic [3:0] HOUR_LAST_STEP = 4'(HOUR_STEPS - 1);
    localparam logic [3:0] MIN_LAST_STEP  = 4'(MIN_STEPS - 1);
    localparam logic [3:0] WK_LAST_STEP   = 4'(WK_STEPS - 1);

    // Valid over 1970..2106, where 2100 is the only century that is not leap
    function automatic logic is_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != NOLEAP_CENTURY);
    endfunction

    function automatic logic [8:0] year_len(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [8:0] month_len(input logic leap, input logic [3:0] mo);
        logic [8:0] len;
        unique case (mo)
            4'd2:                      len = leap ? 9'd29 : 9'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 9'd30;
            default:                   len = 9'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

### sv/rtc_epoch_calendar_converter.sv
// Top level of the RTC epoch/calendar converter: sequencer, shared subtractor
// and output register.
// Depends on rtc_cal_pkg.
//
// Converts Unix epoch seconds into calendar fields and packed RTC date/time
// words (op 0), or packed RTC words back into epoch seconds (op 1). One beat
// is worked at a time by a small sequencer around one shared 33-bit
// subtract/compare unit that performs restoring division steps and the year
// and month walks. Op 0 goes through the accept state, 40 division steps, a
// year walk over Y, the whole years since 1970 (up to 136), a month walk
// over M, the whole months into the year (up to 11), and the done state. Op 1
// goes through the accept state, a year sum over Y, the years from 1970 to
// the packed year (up to 63 + 40), a month sum over M, the months before
// the packed month (up to 11), a multiply and an add state, 29 division
// steps for the weekday, and the done state. in_stall
// is low only while the sequencer is idle. A finished result moves into the
// output register and waits there; while an earlier result is still stalled
// in it, the sequencer holds in its done state and the next input beat waits.
`default_nettype none

module rtc_epoch_calendar_converter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [31:0] epoch_seconds,
    input  wire logic [31:0] date_word,
    input  wire logic [31:0] time_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      seconds_out,
    output logic [22:0]      date_out,
    output logic [31:0]      time_out,
    output logic [11:0]      year,
    output logic [3:0]       month,
    output logic [4:0]       day_of_month,
    output logic [4:0]       hour,
    output logic [5:0]       minute,
    output logic [5:0]       second,
    output logic [2:0]       weekday,
    output logic             leap_year,
    output logic             bad_month
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_DDAY  = 12'b0000_0000_0010,
        S_DHOUR = 12'b0000_0000_0100,
        S_DMIN  = 12'b0000_0000_1000,
        S_DWK   = 12'b0000_0001_0000,
        S_YEAR  = 12'b0000_0010_0000,
        S_MONTH = 12'b0000_0100_0000,
        S_SUMY  = 12'b0000_1000_0000,
        S_SUMM  = 12'b0001_0000_0000,
        S_MUL   = 12'b0010_0000_0000,
        S_ADD   = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    logic        op_reg, op_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [15:0] quo_reg, quo_next;
    logic [3:0]  step_reg, step_next;
    logic [15:0] day_reg, day_next;
    logic [31:0] acc_reg, acc_next;
    logic [11:0] cy_reg, cy_next;
    logic [3:0]  cm_reg, cm_next;
    logic [11:0] yr_reg, yr_next;
    logic [3:0]  mo_reg, mo_next;
    logic [4:0]  dom_reg, dom_next;
    logic [4:0]  hr_reg, hr_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic [2:0]  wd_reg, wd_next;
    logic        bad_reg, bad_next;

    logic [31:0] seconds_out_reg;
    logic [22:0] date_out_reg;
    logic [31:0] time_out_reg;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_of_month_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [2:0]  weekday_reg;
    logic        leap_year_reg;
    logic        bad_month_reg;

    logic [31:0] sub_b;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] rem_div;
    logic [15:0] quo_div;
    logic [31:0] day_prod;
    logic [16:0] hr_term;
    logic [11:0] min_term;
    logic        in_beat;
    logic        load;
    logic        yr_leap;
    logic [3:0]  mo_raw;

    assign in_beat = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign yr_leap = rtc_cal_pkg::is_leap(yr_reg);
    assign mo_raw = date_word[11:8];

    always_comb
    begin
        unique case (state_reg)
            S_YEAR:  sub_b = 32'(rtc_cal_pkg::year_len(yr_leap));
            S_MONTH: sub_b = 32'(rtc_cal_pkg::month_len(yr_leap, mo_reg));
            default: sub_b = dvs_reg;
        endcase
    end

    assign diff = {1'b0, rem_reg} - {1'b0, sub_b};
    assign ge = !diff[32];
    assign rem_div = ge ? diff[31:0] : rem_reg;
    assign quo_div = {quo_reg[14:0], ge};

    assign day_prod = acc_reg * 32'(rtc_cal_pkg::SECS_PER_DAY);
    assign hr_term = 17'(hr_reg) * rtc_cal_pkg::SECS_PER_HOUR;
    assign min_term = 12'(min_reg) * rtc_cal_pkg::SECS_PER_MIN;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        quo_next = quo_reg;
        step_next = step_reg;
        day_next = day_reg;
        acc_next = acc_reg;
        cy_next = cy_reg;
        cm_next = cm_reg;
        yr_next = yr_reg;
        mo_next = mo_reg;
        dom_next = dom_reg;
        hr_next = hr_reg;
        min_next = min_reg;
        sec_next = sec_reg;
        wd_next = wd_reg;
        bad_next = bad_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    op_next = op;
                    if (!op)
                    begin
                        rem_next = epoch_seconds;
                        dvs_next = rtc_cal_pkg::DAY_DVS;
                        step_next = rtc_cal_pkg::DAY_LAST_STEP;
                        quo_next = '0;
                        bad_next = 1'b0;
                        state_next = S_DDAY;
                    end
                    else
                    begin
                        dom_next = date_word[4:0];
                        yr_next = 12'(date_word[21:16]) + rtc_cal_pkg::BASE_YEAR;
                        sec_next = time_word[5:0];
                        min_next = time_word[13:8];
                        hr_next = time_word[20:16];
                        if (mo_raw == 4'd0)
                        begin
                            mo_next = 4'd1;
                            bad_next = 1'b1;
                        end
                        else if (mo_raw > rtc_cal_pkg::LAST_MONTH)
                        begin
                            mo_next = rtc_cal_pkg::LAST_MONTH;
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            mo_next = mo_raw;
                            bad_next = 1'b0;
                        end
                        cy_next = rtc_cal_pkg::EPOCH_YEAR;
                        acc_next = '0;
                        state_next = S_SUMY;
                    end
                end
            end
            S_DDAY:
            begin
                rem_next = rem_div;
                quo_next = quo_div;
                dvs_next = dvs_reg >> 1;
                step_next = step_reg - 4'd1;
                if (step_reg == 4'd0)
                begin
                    day_next = quo_div;
                    quo_next = '0;
                    if (!op_reg)
                    begin
                        dvs_next = rtc_cal_pkg::HOUR_DVS;
                        step_next = rtc_cal_pkg::HOUR_LAST_STEP;
                        state_next = S_DHOUR;
                    end
                    else
                    begin
                        rem_next = 32'(quo_div) + rtc_cal_pkg::WEEKDAY_BIAS;
                        dvs_next = rtc_cal_pkg::WK_DVS;
                        step_next = rtc_cal_pkg::WK_LAST_STEP;
                        state_next = S_DWK;
                    end
                end
            end
            S_DHOUR:
            begin
                rem_next = rem_div;
                quo_next = quo_div;
                dvs_next = dvs_reg >> 1;
                step_next = step_reg - 4'd1;
                if (step_reg == 4'd0)
                begin
                    hr_next = quo_div[4:0];
                    quo_next = '0;
                    dvs_next = rtc_cal_pkg::MIN_DVS;
                    step_next = rtc_cal_pkg::MIN_LAST_STEP;
                    state_next = S_DMIN;
                end
            end
            S_DMIN:
            begin
                rem_next = rem_div;
                quo_next = quo_div;
                dvs_next = dvs_reg >> 1;
                step_next = step_reg - 4'd1;
                if (step_reg == 4'd0)
                begin
                    min_next = quo_div[5:0];
                    sec_next = rem_div[5:0];
                    quo_next = '0;
                    rem_next = 32'(day_reg) + rtc_cal_pkg::WEEKDAY_BIAS;
                    dvs_next = rtc_cal_pkg::WK_DVS;
                    step_next = rtc_cal_pkg::WK_LAST_STEP;
                    state_next = S_DWK;
                end
            end
            S_DWK:
            begin
                rem_next = rem_div;
                quo_next = quo_div;
                dvs_next = dvs_reg >> 1;
                step_next = step_reg - 4'd1;
                if (step_reg == 4'd0)
                begin
                    wd_next = rem_div[2:0];
                    if (!op_reg)
                    begin
                        rem_next = 32'(day_reg);
                        yr_next = rtc_cal_pkg::EPOCH_YEAR;
                        state_next = S_YEAR;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_YEAR:
            begin
                if (ge)
                begin
                    rem_next = diff[31:0];
                    yr_next = yr_reg + 12'd1;
                end
                else
                begin
                    mo_next = 4'd1;
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                if (mo_reg < rtc_cal_pkg::LAST_MONTH && ge)
                begin
                    rem_next = diff[31:0];
                    mo_next = mo_reg + 4'd1;
                end
                else
                begin
                    dom_next = rem_reg[4:0] + 5'd1;
                    state_next = S_DONE;
                end
            end
            S_SUMY:
            begin
                if (cy_reg == yr_reg)
                begin
                    cm_next = 4'd1;
                    state_next = S_SUMM;
                end
                else
                begin
                    acc_next = acc_reg
                        + 32'(rtc_cal_pkg::year_len(rtc_cal_pkg::is_leap(cy_reg)));
                    cy_next = cy_reg + 12'd1;
                end
            end
            S_SUMM:
            begin
                if (cm_reg == mo_reg)
                begin
                    acc_next = acc_reg + 32'(dom_reg) - 32'd1;
                    state_next = S_MUL;
                end
                else
                begin
                    acc_next = acc_reg + 32'(rtc_cal_pkg::month_len(yr_leap, cm_reg));
                    cm_next = cm_reg + 4'd1;
                end
            end
            S_MUL:
            begin
                acc_next = day_prod;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                acc_next = acc_reg + 32'(hr_term) + 32'(min_term) + 32'(sec_reg);
                rem_next = acc_next;
                dvs_next = rtc_cal_pkg::DAY_DVS;
                step_next = rtc_cal_pkg::DAY_LAST_STEP;
                quo_next = '0;
                state_next = S_DDAY;
            end
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && out_stall) || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        step_reg <= step_next;
        day_reg <= day_next;
        acc_reg <= acc_next;
        cy_reg <= cy_next;
        cm_reg <= cm_next;
        yr_reg <= yr_next;
        mo_reg <= mo_next;
        dom_reg <= dom_next;
        hr_reg <= hr_next;
        min_reg <= min_next;
        sec_reg <= sec_next;
        wd_reg <= wd_next;
        bad_reg <= bad_next;
    end

    // Hold the result beat until taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            seconds_out_reg <= op_reg ? acc_reg : 32'd0;
            date_out_reg <= {yr_leap, 6'(yr_reg - rtc_cal_pkg::BASE_YEAR), 4'd0,
                             mo_reg, 3'd0, dom_reg};
            time_out_reg <= {wd_reg, 8'd0, hr_reg, 2'd0, min_reg, 2'd0, sec_reg};
            year_reg <= yr_reg;
            month_reg <= mo_reg;
            day_of_month_reg <= dom_reg;
            hour_reg <= hr_reg;
            minute_reg <= min_reg;
            second_reg <= sec_reg;
            weekday_reg <= wd_reg;
            leap_year_reg <= yr_leap;
            bad_month_reg <= bad_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign seconds_out = seconds_out_reg;
    assign date_out = date_out_reg;
    assign time_out = time_out_reg;
    assign year = year_reg;
    assign month = month_reg;
    assign day_of_month = day_of_month_reg;
    assign hour = hour_reg;
    assign minute = minute_reg;
    assign second = second_reg;
    assign weekday = weekday_reg;
    assign leap_year = leap_year_reg;
    assign bad_month = bad_month_reg;

endmodule

`default_nettype wire
